### src/framed_packet_receiver_core_assert.svh
// Assertion macros used by the framed packet receiver RTL.
// Depends on nothing; included by framed_packet_receiver_core, which carries assertions.
`ifndef FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framed packet receiver: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framed packet receiver: next-cycle check failed");

`endif

### src/fpr_pkg.sv
// Types and constants of the framed packet receiver.
// Depends on nothing; used by framed_packet_receiver_core.
`timescale 1ns / 1ps

package fpr_pkg;

   typedef logic [2:0] fpr_phase_type;
   typedef logic [2:0] fpr_event_type;
   typedef logic [1:0] fpr_csr_index_type;

   localparam fpr_phase_type PH_HUNT    = 3'd0;
   localparam fpr_phase_type PH_CMD     = 3'd1;
   localparam fpr_phase_type PH_LEN     = 3'd2;
   localparam fpr_phase_type PH_PAYLOAD = 3'd3;
   localparam fpr_phase_type PH_CHECK   = 3'd4;

   localparam fpr_event_type EV_PAYLOAD = 3'd0;
   localparam fpr_event_type EV_OK      = 3'd1;
   localparam fpr_event_type EV_LENGTH  = 3'd2;
   localparam fpr_event_type EV_CHECK   = 3'd3;
   localparam fpr_event_type EV_TIMEOUT = 3'd4;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam fpr_csr_index_type CSR_START_BYTE    = 2'd0;
   localparam fpr_csr_index_type CSR_MAX_PAYLOAD   = 2'd1;
   localparam fpr_csr_index_type CSR_TIMEOUT_TICKS = 2'd2;

   localparam int          TIMEOUT_BITS          = 16;
   localparam logic [7:0]  CHECK_SEED            = 8'h55;
   localparam logic [7:0]  START_BYTE_RESET      = 8'h00;
   localparam logic [7:0]  MAX_PAYLOAD_RESET     = 8'hFF;
   localparam logic [15:0] TIMEOUT_TICKS_RESET   = 16'd100;

endpackage

### src/framed_packet_receiver_core.sv
// Framed packet receiver core: start byte hunt, header, payload, XOR check and tick timeout.
// A result appears in the output register in the cycle after its item is taken.
// Throughput: one item per cycle; an item is taken while a result waits if it is taken now.
// Reset is synchronous and active high; it restores all but the output data registers and hunts.
// Depends on fpr_pkg and framed_packet_receiver_core_assert.svh.
`timescale 1ns / 1ps
`include "framed_packet_receiver_core_assert.svh"

module framed_packet_receiver_core
   import fpr_pkg::*;
#(
   parameter int TICK_COUNTER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fpr_event_type            rsp_event_res,
   output logic [7:0]               rsp_payload_byte,
   output logic [7:0]               rsp_payload_index,
   output logic [7:0]               rsp_frame_command,
   output logic [7:0]               rsp_frame_length,
   input  logic                     csr_write_en,
   input  fpr_csr_index_type        csr_index,
   input  logic [TIMEOUT_BITS-1:0]  csr_write_data
);

   localparam int CMP_BITS = (TICK_COUNTER_BITS > TIMEOUT_BITS) ? TICK_COUNTER_BITS
                                                                : TIMEOUT_BITS;

   logic [7:0]              start_byte_ff;
   logic [7:0]              max_payload_ff;
   logic [TIMEOUT_BITS-1:0] timeout_ticks_ff;

   fpr_phase_type               phase_ff, phase_in;
   logic [7:0]                  check_ff, check_in;
   logic [7:0]                  command_ff, command_in;
   logic [7:0]                  length_ff, length_in;
   logic [7:0]                  position_ff, position_in;
   logic [TICK_COUNTER_BITS-1:0] quiet_ff, quiet_in;

   logic                    rsp_valid_ff;
   fpr_event_type           event_ff;
   logic [7:0]              byte_ff;
   logic [7:0]              index_ff;
   logic [7:0]              command_out_ff;
   logic [7:0]              length_out_ff;

   logic                         accept;
   logic                         emit;
   fpr_event_type                event_in;
   logic [7:0]                   byte_in;
   logic [7:0]                   index_in;
   logic [TICK_COUNTER_BITS-1:0] quiet_inc;
   logic [TIMEOUT_BITS-1:0]      limit;
   logic [7:0]                   position_inc;
   logic [7:0]                   check_xor;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign quiet_inc    = (quiet_ff == '1) ? quiet_ff : quiet_ff + 1'b1;
   assign limit        = (timeout_ticks_ff == '0) ? TIMEOUT_BITS'(1) : timeout_ticks_ff;
   assign position_inc = position_ff + 8'd1;
   assign check_xor    = check_ff ^ req_rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      check_in    = check_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      position_in = position_ff;
      quiet_in    = quiet_ff;
      emit        = 1'b0;
      event_in    = EV_PAYLOAD;
      byte_in     = 8'd0;
      index_in    = 8'd0;
      if (accept) begin
         if (req_cmd == KIND_TICK) begin
            if (phase_ff != PH_HUNT) begin
               quiet_in = quiet_inc;
               if (CMP_BITS'(quiet_inc) >= CMP_BITS'(limit)) begin
                  emit        = 1'b1;
                  event_in    = EV_TIMEOUT;
                  phase_in    = PH_HUNT;
                  check_in    = CHECK_SEED;
                  position_in = 8'd0;
                  quiet_in    = '0;
               end
            end
         end else if (phase_ff == PH_HUNT) begin
            if (req_rx_byte == start_byte_ff) begin
               phase_in    = PH_CMD;
               check_in    = CHECK_SEED ^ req_rx_byte;
               command_in  = 8'd0;
               length_in   = 8'd0;
               position_in = 8'd0;
               quiet_in    = '0;
            end
         end else begin
            quiet_in = '0;
            check_in = check_xor;
            case (phase_ff)
               PH_CMD: begin
                  command_in = req_rx_byte;
                  phase_in   = PH_LEN;
               end
               PH_LEN: begin
                  length_in = req_rx_byte;
                  if (req_rx_byte > max_payload_ff) begin
                     emit        = 1'b1;
                     event_in    = EV_LENGTH;
                     phase_in    = PH_HUNT;
                     check_in    = CHECK_SEED;
                     position_in = 8'd0;
                  end else if (req_rx_byte == 8'd0) begin
                     phase_in = PH_CHECK;
                  end else begin
                     position_in = 8'd0;
                     phase_in    = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  emit        = 1'b1;
                  event_in    = EV_PAYLOAD;
                  byte_in     = req_rx_byte;
                  index_in    = position_ff;
                  position_in = position_inc;
                  if (position_inc == length_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  emit        = 1'b1;
                  event_in    = (check_xor == 8'd0) ? EV_OK : EV_CHECK;
                  phase_in    = PH_HUNT;
                  check_in    = CHECK_SEED;
                  position_in = 8'd0;
               end
               default: begin
                  phase_in    = PH_HUNT;
                  check_in    = CHECK_SEED;
                  position_in = 8'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= START_BYTE_RESET;
         max_payload_ff   <= MAX_PAYLOAD_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_START_BYTE:    start_byte_ff    <= csr_write_data[7:0];
            CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_write_data[7:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         check_ff     <= CHECK_SEED;
         command_ff   <= 8'd0;
         length_ff    <= 8'd0;
         position_ff  <= 8'd0;
         quiet_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         check_ff    <= check_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         quiet_ff    <= quiet_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         event_ff       <= event_in;
         byte_ff        <= byte_in;
         index_ff       <= index_in;
         command_out_ff <= command_in;
         length_out_ff  <= length_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = event_ff;
   assign rsp_payload_byte  = byte_ff;
   assign rsp_payload_index = index_ff;
   assign rsp_frame_command = command_out_ff;
   assign rsp_frame_length  = length_out_ff;

   `FPR_ASSERT_SAME(a_payload_index_in_frame, clock, reset,
      rsp_valid_ff && (event_ff == EV_PAYLOAD), index_ff < length_out_ff)
   `FPR_ASSERT_SAME(a_outcome_has_no_payload, clock, reset,
      rsp_valid_ff && (event_ff != EV_PAYLOAD), (byte_ff == 8'd0) && (index_ff == 8'd0))
   `FPR_ASSERT_SAME(a_hunt_counters_clear, clock, reset,
      phase_ff == PH_HUNT, (quiet_ff == '0) && (position_ff == 8'd0) && (check_ff == CHECK_SEED))
   `FPR_ASSERT_NEXT(a_outcome_returns_to_hunt, clock, reset,
      emit && (event_in != EV_PAYLOAD), phase_ff == PH_HUNT)

endmodule
